// ===== hdl/bmm_pkg.sv =====
// Shared types, codes and helper functions for the banked memory mapper with clock.
// No dependencies; every other file in hdl/ imports this package.
package bmm_pkg;

    localparam int ROM_BANK_BITS_DEF = 7;
    localparam int DAY_LIMIT_DEF     = 512;

    localparam logic [7:0] RTC_S    = 8'h08;
    localparam logic [7:0] RTC_LAST = 8'h0C;
    localparam logic [7:0] OPEN_BUS = 8'hFF;

    // Clock register positions, in select order from RTC_S upwards
    localparam logic [2:0] CLK_SEC    = 3'd0;
    localparam logic [2:0] CLK_MIN    = 3'd1;
    localparam logic [2:0] CLK_HOUR   = 3'd2;
    localparam logic [2:0] CLK_DAY_LO = 3'd3;
    localparam logic [2:0] CLK_DAY_HI = 3'd4;
    localparam int         CLK_BYTES  = 5;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROM_SIZE = 2'd0;
    localparam logic [1:0] CFG_RAM_SIZE = 2'd1;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        TGT_NONE      = 3'd0,
        TGT_ROM_READ  = 3'd1,
        TGT_RAM_READ  = 3'd2,
        TGT_RAM_WRITE = 3'd3,
        TGT_DATA      = 3'd4
    } target_t;

    typedef struct packed {
        target_t     target;
        logic [22:0] mem_address;
        logic [7:0]  mem_write_data;
        logic [7:0]  read_data;
    } result_t;

    // State updates requested by the decoder for one transaction
    typedef struct packed {
        logic wr_enable;
        logic wr_bank;
        logic wr_select;
        logic wr_latch;
        logic wr_clock;
        logic tick;
    } map_ctrl_t;

    // Commands to the clock block
    typedef struct packed {
        logic       tick;
        logic       latch;
        logic       clk_wr;
        logic [2:0] idx;
        logic [7:0] wdata;
    } rtc_cmd_t;

    // ROM size clamped to 15..23 bits, returned as a 23-bit address mask
    function automatic logic [22:0] rom_mask(input logic [4:0] size_log2);
        logic [4:0] n;
        n = size_log2;
        if (n < 5'd15) n = 5'd15;
        if (n > 5'd23) n = 5'd23;
        return 23'h7FFFFF >> (5'd23 - n);
    endfunction

    // RAM size clamped to 13..17 bits; only the low 16 bits reach an address
    function automatic logic [15:0] ram_mask(input logic [4:0] size_log2);
        logic [4:0]  n;
        logic [16:0] m;
        n = size_log2;
        if (n < 5'd13) n = 5'd13;
        if (n > 5'd17) n = 5'd17;
        m = 17'h1FFFF >> (5'd17 - n);
        return m[15:0];
    endfunction

endpackage

// ===== hdl/bmm_rtc.sv =====
// Clock registers: live counters with the seconds cascade, and the latched copy.
// Depends on bmm_pkg.
module bmm_rtc
    import bmm_pkg::*;
#(
    parameter int DAY_LIMIT = DAY_LIMIT_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  rtc_cmd_t   cmd,
    output logic [7:0] rd_byte
);

    localparam logic [9:0] DAY_LIM = 10'(DAY_LIMIT);

    logic [7:0] sec_reg, min_reg, hrs_reg, day_lo_reg, day_hi_reg;
    logic [7:0] sec_next, min_next, hrs_next, day_lo_next, day_hi_next;
    logic [7:0] latched_reg [CLK_BYTES];

    logic [8:0] sec_inc, min_inc, hrs_inc;
    logic [9:0] day_inc, day_wr;
    logic       sec_wrap, min_wrap, hrs_wrap, day_wrap;

    always_comb begin
        sec_inc  = {1'b0, sec_reg} + 9'd1;
        min_inc  = {1'b0, min_reg} + 9'd1;
        hrs_inc  = {1'b0, hrs_reg} + 9'd1;
        day_inc  = {1'b0, day_hi_reg[0], day_lo_reg} + 10'd1;
        sec_wrap = sec_inc >= 9'd60;
        min_wrap = min_inc >= 9'd60;
        hrs_wrap = hrs_inc >= 9'd24;
        day_wrap = day_inc >= DAY_LIM;
        day_wr   = day_wrap ? day_inc - DAY_LIM : day_inc;

        sec_next    = sec_reg;
        min_next    = min_reg;
        hrs_next    = hrs_reg;
        day_lo_next = day_lo_reg;
        day_hi_next = day_hi_reg;

        // Ripple one second through the units; the counters do not count while halted
        if (cmd.tick && !day_hi_reg[6]) begin
            sec_next = sec_wrap ? 8'(sec_inc - 9'd60) : sec_inc[7:0];
            if (sec_wrap) begin
                min_next = min_wrap ? 8'(min_inc - 9'd60) : min_inc[7:0];
                if (min_wrap) begin
                    hrs_next = hrs_wrap ? 8'(hrs_inc - 9'd24) : hrs_inc[7:0];
                    if (hrs_wrap) begin
                        day_lo_next = day_wr[7:0];
                        day_hi_next = {day_hi_reg[7] | day_wrap, day_hi_reg[6:1], day_wr[8]};
                    end
                end
            end
        end

        if (cmd.clk_wr) begin
            case (cmd.idx)
                CLK_SEC:    sec_next    = cmd.wdata;
                CLK_MIN:    min_next    = cmd.wdata;
                CLK_HOUR:   hrs_next    = cmd.wdata;
                CLK_DAY_LO: day_lo_next = cmd.wdata;
                default:    day_hi_next = cmd.wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_reg    <= '0;
            min_reg    <= '0;
            hrs_reg    <= '0;
            day_lo_reg <= '0;
            day_hi_reg <= '0;
            for (int k = 0; k < CLK_BYTES; k++) latched_reg[k] <= '0;
        end else if (en) begin
            sec_reg    <= sec_next;
            min_reg    <= min_next;
            hrs_reg    <= hrs_next;
            day_lo_reg <= day_lo_next;
            day_hi_reg <= day_hi_next;
            if (cmd.latch) begin
                latched_reg[CLK_SEC]    <= sec_reg;
                latched_reg[CLK_MIN]    <= min_reg;
                latched_reg[CLK_HOUR]   <= hrs_reg;
                latched_reg[CLK_DAY_LO] <= day_lo_reg;
                latched_reg[CLK_DAY_HI] <= day_hi_reg;
            end else if (cmd.clk_wr && cmd.idx <= CLK_DAY_HI) begin
                latched_reg[cmd.idx] <= cmd.wdata;
            end
        end
    end

    assign rd_byte = (cmd.idx <= CLK_DAY_HI) ? latched_reg[cmd.idx] : OPEN_BUS;

endmodule

// ===== hdl/bmm_decode.sv =====
// Address decoder: maps one bus transaction to a result and to mapper state updates.
// Depends on bmm_pkg.
module bmm_decode
    import bmm_pkg::*;
#(
    parameter int ROM_BANK_BITS = ROM_BANK_BITS_DEF
) (
    input  op_t                      op,
    input  logic [15:0]              bus_address,
    input  logic [7:0]               bus_data,
    input  logic                     enable,
    input  logic [ROM_BANK_BITS-1:0] bank_sel,
    input  logic [7:0]               select,
    input  logic [4:0]               rom_size_log2,
    input  logic [4:0]               ram_size_log2,
    input  logic [7:0]               rtc_byte,
    output result_t                  res,
    output map_ctrl_t                ctrl
);

    logic        in_ram_win;
    logic        is_clock;
    logic        no_ram;
    logic [15:0] ram_addr;
    logic [22:0] rom_lo, rom_hi;

    always_comb begin
        in_ram_win = (bus_address inside {[16'hA000:16'hBFFF]}) && enable;
        is_clock   = select inside {[RTC_S:RTC_LAST]};
        no_ram     = ram_size_log2 == 5'd0;
        ram_addr   = {select[2:0], bus_address[12:0]} & ram_mask(ram_size_log2);
        rom_lo     = 23'(bus_address[13:0]) & rom_mask(rom_size_log2);
        rom_hi     = 23'({bank_sel, bus_address[13:0]}) & rom_mask(rom_size_log2);

        res  = '{target: TGT_NONE, mem_address: '0, mem_write_data: '0, read_data: '0};
        ctrl = '0;

        case (op)
            OP_READ: begin
                if (bus_address <= 16'h3FFF) begin
                    res.target      = TGT_ROM_READ;
                    res.mem_address = rom_lo;
                end else if (bus_address <= 16'h7FFF) begin
                    res.target      = TGT_ROM_READ;
                    res.mem_address = rom_hi;
                end else if (in_ram_win && is_clock) begin
                    res.target    = TGT_DATA;
                    res.read_data = rtc_byte;
                end else if (in_ram_win && !no_ram) begin
                    res.target      = TGT_RAM_READ;
                    res.mem_address = 23'(ram_addr);
                end else begin
                    res.target    = TGT_DATA;
                    res.read_data = OPEN_BUS;
                end
            end
            OP_WRITE: begin
                if (bus_address <= 16'h1FFF) begin
                    ctrl.wr_enable = 1'b1;
                end else if (bus_address <= 16'h3FFF) begin
                    ctrl.wr_bank = 1'b1;
                end else if (bus_address <= 16'h5FFF) begin
                    ctrl.wr_select = 1'b1;
                end else if (bus_address <= 16'h7FFF) begin
                    ctrl.wr_latch = 1'b1;
                end else if (in_ram_win && is_clock) begin
                    ctrl.wr_clock = 1'b1;
                end else if (in_ram_win && !no_ram) begin
                    res.target         = TGT_RAM_WRITE;
                    res.mem_address    = 23'(ram_addr);
                    res.mem_write_data = bus_data;
                end
            end
            OP_TICK: ctrl.tick = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== hdl/banked_memory_mapper_with_rtc.sv =====
// Banked memory mapper with real-time clock: top level.
// A transaction accepted into the input stage register is decoded there and moves into the
// result register, which drives m_tvalid. Throughput: one transaction per cycle;
// input stage and result register advance together when the result is free or taken.
// Reset (aresetn low, synchronous) empties both stages and restores all mapper,
// clock and configuration registers to their documented reset values.
module banked_memory_mapper_with_rtc
    import bmm_pkg::*;
#(
    parameter int ROM_BANK_BITS = ROM_BANK_BITS_DEF,
    parameter int DAY_LIMIT     = DAY_LIMIT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input transactions
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] bus_address, [23:16] bus_data
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    // result transactions
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [22:0] mem_address, [30:23] mem_write_data,
                                   // [38:31] read_data, [39] zero
    output logic [2:0]  m_tuser,   // [2:0] target
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    localparam logic [7:0] BANK_MASK = 8'((1 << ROM_BANK_BITS) - 1);

    // Input stage
    logic        in_valid_reg;
    op_t         in_op_reg;
    logic [15:0] in_addr_reg;
    logic [7:0]  in_data_reg;

    // Result stage
    logic        out_valid_reg;
    result_t     out_reg;

    // Mapper and configuration state
    logic                     enable_reg,   enable_next;
    logic [ROM_BANK_BITS-1:0] bank_reg,     bank_next;
    logic [7:0]               select_reg,   select_next;
    logic                     latch_reg,    latch_next;
    logic [4:0]               rom_size_reg, ram_size_reg;

    logic                     advance;
    logic [ROM_BANK_BITS-1:0] bank_wr;
    logic [7:0]               rtc_byte;
    result_t                  res;
    map_ctrl_t                ctrl;
    rtc_cmd_t                 rtc_cmd;

    // Both stages move together; the input stage refills in the same cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload: capture on every accepted transaction, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= op_t'(s_tuser);
            in_addr_reg <= s_tdata[15:0];
            in_data_reg <= s_tdata[23:16];
        end
    end

    bmm_decode #(
        .ROM_BANK_BITS(ROM_BANK_BITS)
    ) u_decode (
        .op            (in_op_reg),
        .bus_address   (in_addr_reg),
        .bus_data      (in_data_reg),
        .enable        (enable_reg),
        .bank_sel      (bank_reg),
        .select        (select_reg),
        .rom_size_log2 (rom_size_reg),
        .ram_size_log2 (ram_size_reg),
        .rtc_byte      (rtc_byte),
        .res           (res),
        .ctrl          (ctrl)
    );

    // Mapper register updates; a bank write of zero selects bank one
    always_comb begin
        bank_wr     = ROM_BANK_BITS'(in_data_reg & BANK_MASK);
        enable_next = enable_reg;
        bank_next   = bank_reg;
        select_next = select_reg;
        latch_next  = latch_reg;
        if (ctrl.wr_enable) enable_next = in_data_reg[3:0] == 4'hA;
        if (ctrl.wr_bank)   bank_next   = (bank_wr == '0) ? ROM_BANK_BITS'(1) : bank_wr;
        if (ctrl.wr_select) select_next = in_data_reg;
        if (ctrl.wr_latch)  latch_next  = in_data_reg[0];
    end

    // Clock commands: latch on a rising edge of the latch bit only
    always_comb begin
        rtc_cmd.tick   = ctrl.tick;
        rtc_cmd.latch  = ctrl.wr_latch && !latch_reg && in_data_reg[0];
        rtc_cmd.clk_wr = ctrl.wr_clock;
        rtc_cmd.idx    = 3'(select_reg - RTC_S);
        rtc_cmd.wdata  = in_data_reg;
    end

    bmm_rtc #(
        .DAY_LIMIT(DAY_LIMIT)
    ) u_rtc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .cmd     (rtc_cmd),
        .rd_byte (rtc_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b1;
            bank_reg      <= ROM_BANK_BITS'(1);
            select_reg    <= '0;
            latch_reg     <= 1'b0;
            rom_size_reg  <= 5'd15;
            ram_size_reg  <= 5'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                enable_reg <= enable_next;
                bank_reg   <= bank_next;
                select_reg <= select_next;
                latch_reg  <= latch_next;
            end
            // Drop the result once taken, unless a new one replaces it
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ROM_SIZE: rom_size_reg <= cfg_data;
                    CFG_RAM_SIZE: ram_size_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.target;
    assign m_tdata  = {1'b0, out_reg.read_data, out_reg.mem_write_data, out_reg.mem_address};

endmodule

// ===== hdl/bmm_chk.sv =====
// Port-level checker for the banked memory mapper, bound to the top level.
// Depends on bmm_pkg and the top level's port list.
module bmm_chk
    import bmm_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_target: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= TGT_DATA)
        else $error("target code out of range");

    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == TGT_NONE || m_tuser == TGT_DATA) |-> m_tdata[22:0] == 23'd0)
        else $error("address given without a memory access");

    a_wdata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != TGT_RAM_WRITE |-> m_tdata[30:23] == 8'd0)
        else $error("write data given without a RAM write");

    a_rdata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != TGT_DATA |-> m_tdata[39:31] == 9'd0)
        else $error("read data given without a data result");

endmodule

bind banked_memory_mapper_with_rtc bmm_chk u_bmm_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
